>>> rtl/tss_pkg.sv
// shared constants, status codes and saturating fixed-point helpers
package tss_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int FRAC_BITS = 16;
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int IDX_W     = $clog2(MAX_ROWS);
  localparam int DIV_W     = 32 + FRAC_BITS;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_PIVOT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // fixed-point product scaling, floor rounding, saturated
  function automatic logic signed [31:0] fx_scale(input logic signed [63:0] p);
    return sat64(p >>> FRAC_BITS);
  endfunction

  // saturating difference
  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
    logic signed [32:0] s;
    s = 33'(x) - 33'(y);
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
    else return s[31:0];
  endfunction

endpackage

>>> rtl/tridiagonal_system_solver.sv
// tridiagonal solver top level: forward sweep into row memories, back substitution
//
// input channel: one beat per row of the system (sub, main, super diagonal and
// right-hand side, plus a last-row flag). the forward sweep for a row runs as
// soon as the row is taken; in_ready_o is low while it runs.
// a row with a nonzero pivot needs two Q16.16 quotients in turn from the shared
// one-bit-per-cycle divider; row 0 skips the memory read and multiplies.
// output channel: after the row flagged last, one beat per stored row, from
// the highest row down to row 0, each passing the read, multiply and subtract
// states and held by any stall; the first one follows the sweep of the last
// row through the same states. a stalled receiver holds the result register
// and the sequencer; no input is taken until row 0 has gone out.
// status is the same on every beat of a run: ok, zero pivot or too many rows.
// reset clears the row count, the error code and the sequencer; the row
// memories need no clearing since only rows of the current run are read.
module tridiagonal_system_solver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] sub_diag_i,
  input  logic signed [31:0] main_diag_i,
  input  logic signed [31:0] super_diag_i,
  input  logic signed [31:0] rhs_value_i,
  input  logic               last_row_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] solution_o,
  output logic [5:0]         row_index_o,
  output logic               last_value_o,
  output logic [1:0]         status_o
);
  import tss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FRD, S_FMA, S_FMB, S_FMC, S_CHK, S_DC, S_DD, S_WR,
    S_BRD, S_BMUL, S_BSUB, S_BOUT
  } state_e;

  state_e state_q;

  // control state
  logic [CNT_W-1:0] row_cnt_q;
  logic [1:0]       err_q;
  logic [IDX_W-1:0] bidx_q;
  logic             first_q;

  // row operands and intermediate values
  logic signed [31:0] a_q, b_q, c_q, d_q;
  logic               last_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] piv_q, ds_q, cs_q, x_q;

  // row memories: modified super diagonal and right-hand side
  logic signed [31:0] sup_mem [MAX_ROWS];
  logic signed [31:0] rhs_mem [MAX_ROWS];
  logic signed [31:0] sup_rd_q, rhs_rd_q;

  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_p1;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             wr_en;

  logic               div_start;
  logic signed [31:0] div_num;
  logic               div_done;
  logic signed [31:0] div_quo;

  logic in_acc, out_acc;

  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_valid_o = state_q == S_BOUT;
  assign out_acc    = out_valid_o && out_ready_i;

  assign cnt_m1  = row_cnt_q - CNT_W'(1);
  assign cnt_p1  = row_cnt_q + CNT_W'(1);
  assign rd_addr = (state_q == S_BRD) ? bidx_q : cnt_m1[IDX_W-1:0];
  assign rd_en   = (state_q == S_BRD) || (state_q == S_FRD);
  assign wr_en   = state_q == S_WR;

  // divider gets c first, then the reduced right-hand side
  assign div_start = ((state_q == S_CHK) && (piv_q != 32'sd0)) ||
                     ((state_q == S_DC) && div_done);
  assign div_num   = (state_q == S_CHK) ? c_q : ds_q;

  tss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (piv_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sup_mem[row_cnt_q[IDX_W-1:0]] <= cs_q;
      rhs_mem[row_cnt_q[IDX_W-1:0]] <= ds_q;
    end
    if (rd_en) begin
      sup_rd_q <= sup_mem[rd_addr];
      rhs_rd_q <= rhs_mem[rd_addr];
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_cnt_q <= '0;
      err_q     <= STAT_OK;
      bidx_q    <= '0;
      first_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            a_q    <= sub_diag_i;
            b_q    <= main_diag_i;
            c_q    <= last_row_i ? 32'sd0 : super_diag_i;
            d_q    <= rhs_value_i;
            last_q <= last_row_i;
            if (row_cnt_q >= CNT_W'(MAX_ROWS)) begin
              // row beyond capacity is dropped
              err_q <= STAT_FULL;
              if (last_row_i) begin
                bidx_q  <= cnt_m1[IDX_W-1:0];
                first_q <= 1'b1;
                state_q <= S_BRD;
              end
            end else if (row_cnt_q == '0) begin
              piv_q   <= main_diag_i;
              ds_q    <= rhs_value_i;
              state_q <= S_CHK;
            end else begin
              state_q <= S_FRD;
            end
          end
        end
        S_FRD: state_q <= S_FMA;
        S_FMA: begin
          prod_q  <= a_q * sup_rd_q;
          state_q <= S_FMB;
        end
        S_FMB: begin
          piv_q   <= fx_sub(b_q, fx_scale(prod_q));
          prod_q  <= a_q * rhs_rd_q;
          state_q <= S_FMC;
        end
        S_FMC: begin
          ds_q    <= fx_sub(d_q, fx_scale(prod_q));
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (piv_q == 32'sd0) begin
            if (err_q == STAT_OK) err_q <= STAT_PIVOT;
            cs_q    <= 32'sd0;
            ds_q    <= 32'sd0;
            state_q <= S_WR;
          end else begin
            state_q <= S_DC;
          end
        end
        S_DC: begin
          if (div_done) begin
            cs_q    <= div_quo;
            state_q <= S_DD;
          end
        end
        S_DD: begin
          if (div_done) begin
            ds_q    <= div_quo;
            state_q <= S_WR;
          end
        end
        S_WR: begin
          row_cnt_q <= cnt_p1;
          if (last_q) begin
            bidx_q  <= row_cnt_q[IDX_W-1:0];
            first_q <= 1'b1;
            state_q <= S_BRD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_BRD: state_q <= S_BMUL;
        S_BMUL: begin
          prod_q  <= sup_rd_q * x_q;
          state_q <= S_BSUB;
        end
        S_BSUB: begin
          x_q     <= first_q ? rhs_rd_q : fx_sub(rhs_rd_q, fx_scale(prod_q));
          first_q <= 1'b0;
          state_q <= S_BOUT;
        end
        S_BOUT: begin
          if (out_ready_i) begin
            if (bidx_q == '0) begin
              // end of run, rearm for a new system
              row_cnt_q <= '0;
              err_q     <= STAT_OK;
              state_q   <= S_IDLE;
            end else begin
              bidx_q  <= bidx_q - IDX_W'(1);
              state_q <= S_BRD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign solution_o   = x_q;
  assign row_index_o  = 6'(bidx_q);
  assign last_value_o = bidx_q == '0;
  assign status_o     = err_q;

  // no row is taken while a solution beat is pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during back substitution");

  // row count never exceeds capacity
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_cnt_q <= CNT_W'(MAX_ROWS)) else $error("row count overflow");

  // the final beat rearms the block
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_value_o) |=> (row_cnt_q == '0 && err_q == STAT_OK && in_ready_o))
    else $error("run not cleared after row 0");

  // divider is started only by the sweep of a nonzero pivot
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (piv_q != 32'sd0)) else $error("divide by zero pivot");

endmodule

>>> rtl/tss_div.sv
// radix-2 restoring divider for (num << FRAC_BITS) / den, saturated to 32 bits
module tss_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);
  import tss_pkg::*;

  localparam int DCNT_W = $clog2(DIV_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]  numr_q;
  logic [DIV_W-1:0]  quo_q;
  logic [32:0]       rem_q;
  logic [31:0]       den_q;
  logic              neg_q;

  logic [32:0] rem_sh;
  logic        take;
  logic [31:0] num_mag;
  logic [31:0] den_mag;

  assign num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign den_mag = den_i[31] ? 32'(-den_i) : 32'(den_i);
  assign rem_sh  = {rem_q[31:0], numr_q[DIV_W-1]};
  assign take    = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      numr_q <= {num_mag, {FRAC_BITS{1'b0}}};
      den_q  <= den_mag;
      rem_q  <= '0;
      quo_q  <= '0;
      neg_q  <= num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      numr_q <= {numr_q[DIV_W-2:0], 1'b0};
      rem_q  <= take ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_q  <= {quo_q[DIV_W-2:0], take};
    end
  end

  always_comb begin
    if (!neg_q) begin
      quo_o = (|quo_q[DIV_W-1:31]) ? 32'sh7fffffff : $signed(quo_q[31:0]);
    end else begin
      quo_o = (|quo_q[DIV_W-1:31]) ? 32'sh80000000 : $signed(32'(-quo_q[31:0]));
    end
  end

  assign done_o = done_q;

endmodule

>>> verif/tb_top.sv
// testbench for the tridiagonal solver: row stimulus, thomas-algorithm predictor, result checks
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tss_pkg::*;

  typedef struct packed {
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic               last_value;
    logic [1:0]         status;
  } sol_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] sub_diag_i = '0;
  logic signed [31:0] main_diag_i = '0;
  logic signed [31:0] super_diag_i = '0;
  logic signed [31:0] rhs_value_i = '0;
  logic               last_row_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] solution_o;
  logic [5:0]         row_index_o;
  logic               last_value_o;
  logic [1:0]         status_o;

  tridiagonal_system_solver u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state: modified super diagonal and rhs, stored row count, error code
  logic signed [31:0] cprime [MAX_ROWS];
  logic signed [31:0] dprime [MAX_ROWS];
  int unsigned        rows_held;
  logic [1:0]         err_code;
  sol_t               sol_q[$];

  int  mismatches = 0;
  int  unexpected = 0;
  int  stall_cycles = 0;
  bit  idle_free = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // product with floor rounding, saturated
  function automatic logic signed [31:0] qmul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [65:0] p;
    p = 66'(x) * 66'(y);
    return clamp32(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    return clamp32(66'(x) - 66'(y));
  endfunction

  // quotient truncated toward zero, saturated
  function automatic logic signed [31:0] qdiv(input logic signed [31:0] n,
                                              input logic signed [31:0] d);
    logic signed [65:0] nn;
    nn = 66'(n) <<< FRAC_BITS;
    return clamp32(nn / 66'(d));
  endfunction

  // forward sweep of one row, back substitution on the last one
  task automatic sweep_row(input logic signed [31:0] a, b, c, d, input logic lst);
    logic signed [31:0] piv, ds, x;
    sol_t s;
    int unsigned n;
    if (rows_held >= MAX_ROWS) begin
      rows_held = MAX_ROWS;
      err_code = STAT_FULL;
    end else begin
      if (lst) c = '0;
      if (rows_held == 0) begin
        piv = b;
        ds = d;
      end else begin
        piv = qsub(b, qmul(a, cprime[rows_held-1]));
        ds = qsub(d, qmul(a, dprime[rows_held-1]));
      end
      if (piv == 0) begin
        if (err_code == STAT_OK) err_code = STAT_PIVOT;
        cprime[rows_held] = '0;
        dprime[rows_held] = '0;
      end else begin
        cprime[rows_held] = qdiv(c, piv);
        dprime[rows_held] = qdiv(ds, piv);
      end
      rows_held++;
    end
    if (!lst) return;
    n = rows_held;
    x = '0;
    for (int i = n - 1; i >= 0; i--) begin
      if (i == n - 1) x = dprime[i];
      else x = qsub(dprime[i], qmul(cprime[i], x));
      s.solution = x;
      s.row_index = i[5:0];
      s.last_value = (i == 0);
      s.status = err_code;
      sol_q = {sol_q, s};
    end
    rows_held = 0;
    err_code = STAT_OK;
  endtask

  // send one row beat, then update the predictor
  task automatic send_row(input logic signed [31:0] a, b, c, d, input logic lst);
    while (!idle_free && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sub_diag_i <= a;
    main_diag_i <= b;
    super_diag_i <= c;
    rhs_value_i <= d;
    last_row_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    sweep_row(a, b, c, d, lst);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sol_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // well-conditioned Q16.16 value in about +-mag
  function automatic logic signed [31:0] rnd_q(input int mag);
    return $signed($urandom_range(2 * mag)) - mag;
  endfunction

  task automatic send_system(input int n, input bit dominant);
    logic signed [31:0] a, b, c, d;
    for (int i = 0; i < n; i++) begin
      if (dominant) begin
        a = rnd_q(65536);
        c = rnd_q(65536);
        b = 32'sd196608 + $signed($urandom_range(262144));
        if ($urandom_range(1)) b = -b;
        d = rnd_q(8 << 16);
      end else begin
        a = $urandom;
        b = $urandom;
        c = $urandom;
        d = $urandom;
      end
      send_row(a, b, c, d, i == n - 1);
    end
  endtask

  // extremes of every field and the simplest systems
  task automatic test_directed();
    send_row(32'sh7fffffff, 32'sh00010000, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
    send_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
    send_row('0, 32'sh00000001, 32'sh7fffffff, 32'sh80000000, 1'b0);
    send_row(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1);
    send_row(32'sh00010000, 32'sh00020000, 32'sh00010000, 32'sh00030000, 1'b0);
    send_row(32'sh00010000, 32'sh00020000, 32'sh00010000, 32'sh00030000, 1'b0);
    send_row(32'shffff0000, 32'shfffe0000, 32'sh00010000, 32'shfffd0000, 1'b1);
    drain();
  endtask

  // zero pivot on row 0 and on a later row
  task automatic test_zero_pivot();
    send_row(32'sh1234, '0, 32'sh00010000, 32'sh00050000, 1'b0);
    send_row(32'sh00010000, 32'sh00010000, 32'sh00010000, 32'sh00010000, 1'b1);
    send_row('0, 32'sh00010000, 32'sh00010000, 32'sh00010000, 1'b0);
    send_row(32'sh00010000, 32'sh00010000, '0, 32'sh00020000, 1'b1);
    drain();
  endtask

  // overflow past capacity, with and without a zero pivot first, then a system of exactly capacity
  task automatic test_overflow();
    idle_free = 1;
    send_system(MAX_ROWS + 3, 1);
    idle_free = 0;
    send_row('0, '0, '0, 32'sh00010000, 1'b0);
    send_system(MAX_ROWS + 1, 1);
    send_system(MAX_ROWS, 1);
    drain();
  endtask

  // mostly well-conditioned systems of small size, some raw bit patterns
  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 220) begin
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(MAX_ROWS, 20) : $urandom_range(8, 1);
      send_system(n, $urandom_range(4) != 0);
      sent += n;
      if ($urandom_range(5) == 0) drain();
    end
    drain();
  endtask

  // result channel: random stall, long stall-free stretch in the middle
  always @(posedge clk_i) begin
    out_ready_i <= idle_free || ($urandom_range(99) >= 23);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sol_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected beat: row %0d sol %h", row_index_o, solution_o);
      end else begin
        sol_t e;
        e = sol_q.pop_front();
        if (e.solution !== solution_o || e.row_index !== row_index_o ||
            e.last_value !== last_value_o || e.status !== status_o) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: exp sol %h row %0d last %b st %0d, got %h %0d %b %0d",
                     e.solution, e.row_index, e.last_value, e.status,
                     solution_o, row_index_o, last_value_o, status_o);
        end
      end
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rows_held = 0;
    err_code = STAT_OK;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_pivot();
    test_overflow();
    test_random();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && unexpected == 0 && sol_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> tridiagonal_system_solver.f
rtl/tss_pkg.sv
rtl/tss_div.sv
rtl/tridiagonal_system_solver.sv
verif/tb_top.sv
